// ===== sv/hsvrgb_pkg.sv =====
`default_nettype none

package hsvrgb_pkg;

    localparam int unsigned HUE_W  = 9;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned T_W    = 6;   // ramp position 0..60
    localparam int unsigned K_W    = 14;  // blended ramp weight, at most 255*60
    localparam int unsigned N_W    = 22;  // value times weight, at most 255*255*60
    localparam int unsigned X_W    = 20;  // numerator after dividing by four
    localparam int unsigned M_W    = 21;
    localparam int unsigned P_W    = X_W + M_W;
    localparam int unsigned Q_W    = 16;

    localparam logic [HUE_W-1:0] HUE_CIRCLE = 9'd360;
    localparam logic [HUE_W-1:0] HUE_60     = 9'd60;
    localparam logic [HUE_W-1:0] HUE_120    = 9'd120;
    localparam logic [HUE_W-1:0] HUE_180    = 9'd180;
    localparam logic [HUE_W-1:0] HUE_240    = 9'd240;
    localparam logic [HUE_W-1:0] HUE_300    = 9'd300;
    localparam logic [BYTE_W-1:0] BYTE_MAX  = 8'd255;
    localparam logic [T_W-1:0]   SECTOR_DEG = 6'd60;

    // ceil(2^24 / 15); exact floor(x / 15) for x below 2^24 / 14.
    localparam logic [M_W-1:0] RECIP_15 = 21'd1118482;
    localparam int unsigned    RECIP_SH = 24;

    // Which channel is full and which ramps; the third one is the zero channel.
    typedef enum logic [2:0] {
        SEC_R_FULL_G_RAMP = 3'd0,
        SEC_G_FULL_R_RAMP = 3'd1,
        SEC_G_FULL_B_RAMP = 3'd2,
        SEC_B_FULL_G_RAMP = 3'd3,
        SEC_B_FULL_R_RAMP = 3'd4,
        SEC_R_FULL_B_RAMP = 3'd5
    } sector_t;

    // Exact floor(x / 255) for every x up to 255*256 - 1, which covers 255*255.
    function automatic logic [BYTE_W-1:0] div255(input logic [Q_W-1:0] x);
        logic [Q_W:0] s;
        s = {1'b0, x} + {9'd0, x[Q_W-1:8]} + 17'd1;
        return s[Q_W-1:8];
    endfunction

endpackage

`default_nettype wire

// ===== sv/hsv_to_rgb_converter_unit.sv =====
`default_nettype none

// HSV to RGB pixel converter.
//
// A pixel (hue in degrees, saturation, value) is transferred in at a rising
// clock edge where start is high and busy is low. Busy is held low: the
// converter is a six-stage pipeline and takes a new pixel in every cycle.
// Hue values of 360 and above wrap modulo 360.
//
// Each result appears on red, green and blue for exactly one cycle, marked by
// done, once its pixel has passed through every pipeline register. Results leave
// in the order the pixels arrived, one per pixel. The receiver cannot stall
// the output, so the sustained rate is one pixel per clock, set by the
// pipeline registers between the hue sector logic, the two multiplier stages
// and the constant division stages.
//
// Reset clears only the valid bits of the pipeline; done is low afterwards
// until the first pixel has passed through. The data path carries no state,
// so no flush is needed.
module hsv_to_rgb_converter_unit
    import hsvrgb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [HUE_W-1:0]  hue,
    input  wire logic [BYTE_W-1:0] saturation,
    input  wire logic [BYTE_W-1:0] value,
    output logic                   done,
    output logic [BYTE_W-1:0]      red,
    output logic [BYTE_W-1:0]      green,
    output logic [BYTE_W-1:0]      blue
);

    logic accept;

    // Stage 1: wrapped hue.
    logic              s1_vld_reg, s1_vld_next;
    logic [HUE_W-1:0]  s1_h_reg, s1_h_next;
    logic [BYTE_W-1:0] s1_sat_reg, s1_val_reg;

    // Stage 2: sector and ramp position.
    logic              s2_vld_reg;
    sector_t           s2_sec_reg, s2_sec_next;
    logic [T_W-1:0]    s2_t_reg, s2_t_next;
    logic [BYTE_W-1:0] s2_sat_reg, s2_val_reg;

    // Stage 3: ramp weight and zero-channel product.
    logic              s3_vld_reg;
    sector_t           s3_sec_reg;
    logic [K_W-1:0]    s3_k_reg, s3_k_next;
    logic [Q_W-1:0]    s3_inv_reg, s3_inv_next;
    logic [BYTE_W-1:0] s3_val_reg;

    // Stage 4: ramp numerator and zero-channel level.
    logic              s4_vld_reg;
    sector_t           s4_sec_reg;
    logic [N_W-1:0]    s4_n_reg, s4_n_next;
    logic [BYTE_W-1:0] s4_zero_reg, s4_val_reg;

    // Stage 5: numerator divided by 60.
    logic              s5_vld_reg;
    sector_t           s5_sec_reg;
    logic [Q_W-1:0]    s5_q_reg, s5_q_next;
    logic [BYTE_W-1:0] s5_zero_reg, s5_val_reg;
    logic [P_W-1:0]    prod;

    // Output stage.
    logic              done_reg;
    logic [BYTE_W-1:0] red_reg, red_next;
    logic [BYTE_W-1:0] green_reg, green_next;
    logic [BYTE_W-1:0] blue_reg, blue_next;
    logic [BYTE_W-1:0] ramp;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign s1_vld_next = accept;
    assign s1_h_next   = (hue >= HUE_CIRCLE) ? hue - HUE_CIRCLE : hue;

    // Sectors are half-open on the low side, (60k, 60k+60], with hue 0 in the first.
    always_comb
    begin
        if (s1_h_reg <= HUE_60)
        begin
            s2_sec_next = SEC_R_FULL_G_RAMP;
            s2_t_next   = s1_h_reg[T_W-1:0];
        end
        else if (s1_h_reg <= HUE_120)
        begin
            s2_sec_next = SEC_G_FULL_R_RAMP;
            s2_t_next   = 6'(HUE_120 - s1_h_reg);
        end
        else if (s1_h_reg <= HUE_180)
        begin
            s2_sec_next = SEC_G_FULL_B_RAMP;
            s2_t_next   = 6'(s1_h_reg - HUE_120);
        end
        else if (s1_h_reg <= HUE_240)
        begin
            s2_sec_next = SEC_B_FULL_G_RAMP;
            s2_t_next   = 6'(HUE_240 - s1_h_reg);
        end
        else if (s1_h_reg <= HUE_300)
        begin
            s2_sec_next = SEC_B_FULL_R_RAMP;
            s2_t_next   = 6'(s1_h_reg - HUE_240);
        end
        else
        begin
            s2_sec_next = SEC_R_FULL_B_RAMP;
            s2_t_next   = 6'(HUE_CIRCLE - s1_h_reg);
        end
    end

    // The ramp is val*K/15300 with K = sat*t + (255-sat)*60, which is at most 15300.
    assign s3_k_next = K_W'({6'd0, s2_sat_reg} * {8'd0, s2_t_reg})
                     + K_W'({6'd0, BYTE_MAX - s2_sat_reg} * {8'd0, SECTOR_DEG});
    assign s3_inv_next = {8'd0, BYTE_MAX - s2_sat_reg} * {8'd0, s2_val_reg};

    assign s4_n_next = N_W'({14'd0, s3_val_reg} * {8'd0, s3_k_reg});

    // floor(N/15300) = floor(floor(floor(N/4)/15)/255).
    assign prod      = {{M_W{1'b0}}, s4_n_reg[N_W-1:2]} * {{X_W{1'b0}}, RECIP_15};
    assign s5_q_next = prod[RECIP_SH+Q_W-1:RECIP_SH];

    assign ramp = div255(s5_q_reg);

    always_comb
    begin
        red_next   = s5_zero_reg;
        green_next = s5_zero_reg;
        blue_next  = s5_zero_reg;
        case (s5_sec_reg)
            SEC_R_FULL_G_RAMP:
            begin
                red_next   = s5_val_reg;
                green_next = ramp;
            end
            SEC_G_FULL_R_RAMP:
            begin
                green_next = s5_val_reg;
                red_next   = ramp;
            end
            SEC_G_FULL_B_RAMP:
            begin
                green_next = s5_val_reg;
                blue_next  = ramp;
            end
            SEC_B_FULL_G_RAMP:
            begin
                blue_next  = s5_val_reg;
                green_next = ramp;
            end
            SEC_B_FULL_R_RAMP:
            begin
                blue_next  = s5_val_reg;
                red_next   = ramp;
            end
            default:
            begin
                red_next   = s5_val_reg;
                blue_next  = ramp;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            done_reg   <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_h_reg    <= s1_h_next;
        s1_sat_reg  <= saturation;
        s1_val_reg  <= value;

        s2_sec_reg  <= s2_sec_next;
        s2_t_reg    <= s2_t_next;
        s2_sat_reg  <= s1_sat_reg;
        s2_val_reg  <= s1_val_reg;

        s3_sec_reg  <= s2_sec_reg;
        s3_k_reg    <= s3_k_next;
        s3_inv_reg  <= s3_inv_next;
        s3_val_reg  <= s2_val_reg;

        s4_sec_reg  <= s3_sec_reg;
        s4_n_reg    <= s4_n_next;
        s4_zero_reg <= div255(s3_inv_reg);
        s4_val_reg  <= s3_val_reg;

        s5_sec_reg  <= s4_sec_reg;
        s5_q_reg    <= s5_q_next;
        s5_zero_reg <= s4_zero_reg;
        s5_val_reg  <= s4_val_reg;

        red_reg     <= red_next;
        green_reg   <= green_next;
        blue_reg    <= blue_next;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    // Every transferred pixel produces a result strobe.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##6 done)
        else $error("result strobe missing six cycles after a transfer");

    // Zero saturation gives a gray pixel.
    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && saturation == '0) |-> ##6 (red == green && green == blue))
        else $error("zero saturation did not give equal channels");

    // Zero value gives black.
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && value == '0) |-> ##6 (red == '0 && green == '0 && blue == '0))
        else $error("zero value did not give black");

    // One channel always carries the full value.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##6 (red == $past(value, 6) || green == $past(value, 6)
                        || blue == $past(value, 6)))
        else $error("no channel carries the full value");

endmodule

`default_nettype wire
